// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked while reset is low
`define PAC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// property checked at every edge, reset included
`define PAC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// ----- rtl/core/pac_pkg.sv -----
// ----------------------------------------------------------------------------
// pac_pkg
// Types, constants and cell functions for the QARMA-64 authentication core.
// ----------------------------------------------------------------------------
package pac_pkg;

   localparam int NUM_ROUNDS = 5;
   localparam int NUM_STAGES = 2 * NUM_ROUNDS + 2;
   localparam int CTR_A      = NUM_ROUNDS;
   localparam int CTR_B      = NUM_ROUNDS + 1;

   localparam int CSR_IDX_W  = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_UPPER = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOWER = 1'b1;

   typedef logic [63:0] word_type;
   typedef logic [3:0]  cell_type;

   typedef struct packed {
      word_type w0;
      word_type k0;
   } key_type;

   localparam cell_type CELL_FWD_SRC [16] = '{
      4'd13, 4'd6, 4'd11, 4'd0, 4'd7, 4'd12, 4'd1, 4'd10,
      4'd8, 4'd3, 4'd14, 4'd5, 4'd2, 4'd9, 4'd4, 4'd15
   };
   localparam cell_type CELL_INV_SRC [16] = '{
      4'd3, 4'd6, 4'd12, 4'd9, 4'd14, 4'd11, 4'd1, 4'd4,
      4'd8, 4'd13, 4'd7, 4'd2, 4'd5, 4'd0, 4'd10, 4'd15
   };
   localparam cell_type TWK_FWD_SRC [16] = '{
      4'd4, 4'd5, 4'd6, 4'd7, 4'd11, 4'd2, 4'd3, 4'd8,
      4'd12, 4'd13, 4'd14, 4'd15, 4'd0, 4'd1, 4'd10, 4'd9
   };
   localparam logic [15:0] TWK_FWD_LFSR = 16'hD894;
   localparam cell_type TWK_INV_SRC [16] = '{
      4'd12, 4'd13, 4'd5, 4'd6, 4'd0, 4'd1, 4'd2, 4'd3,
      4'd7, 4'd15, 4'd14, 4'd4, 4'd8, 4'd9, 4'd10, 4'd11
   };
   localparam logic [15:0] TWK_INV_LFSR = 16'h8F41;

   localparam cell_type SBOX_FWD [16] = '{
      4'hB, 4'h6, 4'h8, 4'hF, 4'hC, 4'h0, 4'h9, 4'hE,
      4'h3, 4'h7, 4'h4, 4'h5, 4'hD, 4'h2, 4'h1, 4'hA
   };
   localparam cell_type SBOX_INV [16] = '{
      4'h5, 4'hE, 4'hD, 4'h8, 4'hA, 4'hB, 4'h1, 4'h9,
      4'h2, 4'h6, 4'hF, 4'h0, 4'h4, 4'hC, 4'h7, 4'h3
   };

   localparam word_type ROUND_CONST [NUM_ROUNDS] = '{
      64'h0000000000000000,
      64'h13198A2E03707344,
      64'hA4093822299F31D0,
      64'h082EFA98EC4E6C89,
      64'h452821E638D01377
   };
   localparam word_type ALPHA_CONST = 64'hC0AC29B7C97C50DD;

   function automatic word_type pac_w1(input word_type w0);
      return {w0[0], w0[63:2], w0[1] ^ w0[63]};
   endfunction

   function automatic cell_type lfsr_fwd(input cell_type c);
      return {c[0] ^ c[1], c[3:1]};
   endfunction

   function automatic cell_type lfsr_inv(input cell_type c);
      return {c[2:0], c[0] ^ c[3]};
   endfunction

   function automatic word_type cell_fwd(input word_type v);
      word_type r;
      for (int d = 0; d < 16; d++) begin
         r[d*4 +: 4] = v[{CELL_FWD_SRC[d], 2'b00} +: 4];
      end
      return r;
   endfunction

   function automatic word_type cell_inv(input word_type v);
      word_type r;
      for (int d = 0; d < 16; d++) begin
         r[d*4 +: 4] = v[{CELL_INV_SRC[d], 2'b00} +: 4];
      end
      return r;
   endfunction

   function automatic word_type tweak_fwd(input word_type v);
      word_type r;
      cell_type c;
      for (int d = 0; d < 16; d++) begin
         c = v[{TWK_FWD_SRC[d], 2'b00} +: 4];
         r[d*4 +: 4] = TWK_FWD_LFSR[d] ? lfsr_fwd(c) : c;
      end
      return r;
   endfunction

   function automatic word_type tweak_inv(input word_type v);
      word_type r;
      cell_type c;
      for (int d = 0; d < 16; d++) begin
         c = v[{TWK_INV_SRC[d], 2'b00} +: 4];
         r[d*4 +: 4] = TWK_INV_LFSR[d] ? lfsr_inv(c) : c;
      end
      return r;
   endfunction

   function automatic word_type sbox_fwd(input word_type v);
      word_type r;
      for (int d = 0; d < 16; d++) begin
         r[d*4 +: 4] = SBOX_FWD[v[d*4 +: 4]];
      end
      return r;
   endfunction

   function automatic word_type sbox_inv(input word_type v);
      word_type r;
      for (int d = 0; d < 16; d++) begin
         r[d*4 +: 4] = SBOX_INV[v[d*4 +: 4]];
      end
      return r;
   endfunction

   function automatic cell_type rot1(input cell_type c);
      return {c[2:0], c[3]};
   endfunction

   function automatic cell_type rot2(input cell_type c);
      return {c[1:0], c[3:2]};
   endfunction

   function automatic word_type mix_columns(input word_type v);
      word_type r;
      cell_type a0, a4, a8, ac;
      for (int col = 0; col < 4; col++) begin
         a0 = v[col*4 +: 4];
         a4 = v[col*4 + 16 +: 4];
         a8 = v[col*4 + 32 +: 4];
         ac = v[col*4 + 48 +: 4];
         r[col*4 + 48 +: 4] = rot1(a8) ^ rot2(a4) ^ rot1(a0);
         r[col*4 + 32 +: 4] = rot1(ac) ^ rot1(a4) ^ rot2(a0);
         r[col*4 + 16 +: 4] = rot2(ac) ^ rot1(a8) ^ rot1(a0);
         r[col*4 +: 4]      = rot1(ac) ^ rot2(a8) ^ rot1(a4);
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/pointer_auth_code_cipher_top.sv -----
// Throughput: one request per cycle; busy is never raised.
// Depth is one register stage per forward and per backward round plus two for the reflection.
// Synchronous reset clears the pipeline valid bits and both key registers.
// Results cannot be held off: each shows for one cycle only.
// ----------------------------------------------------------------------------
// pointer_auth_code_cipher_top
// QARMA-64 authentication core with key registers and a round pipeline.
// ----------------------------------------------------------------------------
module pointer_auth_code_cipher_top
   import pac_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [63:0]          req_plain_word,
   input  logic [63:0]          req_tweak,
   output logic                 rsp_valid,
   output logic [63:0]          rsp_auth_code,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_wdata
);

   key_type keys_ff;
   key_type keys_in;

   always_comb begin
      keys_in = keys_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_KEY_UPPER: keys_in.w0 = csr_wdata;
            CSR_KEY_LOWER: keys_in.k0 = csr_wdata;
            default:       keys_in    = keys_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keys_ff <= '0;
      end else begin
         keys_ff <= keys_in;
      end
   end

   assign busy = 1'b0;

   pac_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start & ~busy),
      .in_plain  (req_plain_word),
      .in_tweak  (req_tweak),
      .keys      (keys_ff),
      .out_valid (rsp_valid),
      .out_word  (rsp_auth_code)
   );

endmodule

// ----- rtl/core/pac_pipe.sv -----
// ----------------------------------------------------------------------------
// pac_pipe
// Round pipeline: one stage per forward round, two for the reflection,
// one per backward round.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pac_pipe
   import pac_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  word_type in_plain,
   input  word_type in_tweak,
   input  key_type  keys,
   output logic     out_valid,
   output word_type out_word
);

   logic [NUM_STAGES-1:0] vld_ff;
   word_type              st_ff [NUM_STAGES];
   word_type              st_in [NUM_STAGES];
   word_type              tw_ff [NUM_STAGES-1];
   word_type              tw_in [NUM_STAGES-1];
   word_type              w1;

   assign w1 = pac_w1(keys.w0);

   always_comb begin
      word_type s;
      word_type t;
      // forward rounds
      st_in[0] = sbox_fwd(in_plain ^ keys.w0 ^ keys.k0 ^ in_tweak ^ ROUND_CONST[0]);
      tw_in[0] = tweak_fwd(in_tweak);
      for (int r = 1; r < NUM_ROUNDS; r++) begin
         st_in[r] = sbox_fwd(mix_columns(cell_fwd(
                       st_ff[r-1] ^ keys.k0 ^ tw_ff[r-1] ^ ROUND_CONST[r])));
         tw_in[r] = tweak_fwd(tw_ff[r-1]);
      end
      // reflection, first half
      s = mix_columns(cell_fwd(st_ff[CTR_A-1] ^ w1 ^ tw_ff[CTR_A-1]));
      st_in[CTR_A] = mix_columns(cell_fwd(sbox_fwd(s)));
      tw_in[CTR_A] = tw_ff[CTR_A-1];
      // reflection, second half
      s = sbox_inv(cell_inv(st_ff[CTR_A] ^ keys.k0));
      st_in[CTR_B] = cell_inv(mix_columns(s)) ^ keys.w0 ^ tw_ff[CTR_A];
      tw_in[CTR_B] = tw_ff[CTR_A];
      // backward rounds
      for (int i = 0; i < NUM_ROUNDS - 1; i++) begin
         t = tweak_inv(tw_ff[CTR_B+i]);
         s = cell_inv(mix_columns(sbox_inv(st_ff[CTR_B+i])));
         st_in[CTR_B+1+i] = s ^ ROUND_CONST[NUM_ROUNDS-1-i] ^ keys.k0 ^ t ^ ALPHA_CONST;
         tw_in[CTR_B+1+i] = t;
      end
      t = tweak_inv(tw_ff[NUM_STAGES-2]);
      st_in[NUM_STAGES-1] = sbox_inv(st_ff[NUM_STAGES-2]) ^ ROUND_CONST[0] ^ keys.k0
                            ^ t ^ ALPHA_CONST ^ w1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[NUM_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      for (int n = 0; n < NUM_STAGES; n++) begin
         st_ff[n] <= st_in[n];
      end
      for (int n = 0; n < NUM_STAGES - 1; n++) begin
         tw_ff[n] <= tw_in[n];
      end
   end

   assign out_valid = vld_ff[NUM_STAGES-1];
   assign out_word  = st_ff[NUM_STAGES-1];

   `PAC_ASSERT(a_latency, clock, reset, in_valid |-> ##(NUM_STAGES) out_valid)
   `PAC_ASSERT(a_no_spurious, clock, reset, out_valid |-> $past(vld_ff[NUM_STAGES-2]))
   `PAC_ASSERT_ALWAYS(a_reset_flush, clock, reset |=> (vld_ff == '0))

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the QARMA-64 authentication core. A queue of
// pending requests and key writes feeds a clocked driver; every accepted
// request is scored against a bench-side cipher predictor, and a clocked
// monitor compares each rsp_valid strobe with the oldest prediction. Keys
// are changed only once the pipeline has drained.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE_TICKS = 16;
   localparam int TAIL_TICKS   = 20;
   localparam logic [63:0] ONES = '1;

   // nibble d of a permutation word is the source cell for cell d; of an S-box word, the entry for input d
   localparam logic [63:0] STATE_FWD_PERM = 64'hF4925E38A1C70B6D;
   localparam logic [63:0] STATE_INV_PERM = 64'hFA0527D841BE9C63;
   localparam logic [63:0] TWK_FWD_PERM   = 64'h9A10FEDC832B7654;
   localparam logic [63:0] TWK_INV_PERM   = 64'hBA984EF7321065DC;
   localparam logic [15:0] TWK_FWD_STEP   = 16'hD894;
   localparam logic [15:0] TWK_INV_STEP   = 16'h8F41;
   localparam logic [63:0] SBOX_F         = 64'hA12D5473E90CF86B;
   localparam logic [63:0] SBOX_I         = 64'h37C40F6291BA8DE5;
   localparam logic [63:0] ALPHA          = 64'hC0AC29B7C97C50DD;

   typedef enum logic [1:0] {
      OP_REQUEST,
      OP_KEY_WRITE,
      OP_DRAIN,
      OP_GAP
   } stim_kind_type;

   typedef struct packed {
      stim_kind_type kind;
      logic [63:0]   a;
      logic [63:0]   b;
   } stim_op_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic [63:0]                   req_plain_word = '0;
   logic [63:0]                   req_tweak = '0;
   logic                          rsp_valid;
   logic [63:0]                   rsp_auth_code;
   logic                          csr_wr_en = 1'b0;
   logic [pac_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [63:0]                   csr_wdata = '0;

   stim_op_type stim_q [$];
   logic [63:0] code_q [$];
   logic [63:0] key_w0 = '0;
   logic [63:0] key_k0 = '0;
   int          n_sent = 0;
   int          n_got = 0;
   int          fails = 0;
   bit          stim_done = 1'b0;
   bit          draining = 1'b0;
   int          settle = 0;
   int          gap_pct = 0;

   pointer_auth_code_cipher_top u_top (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_plain_word(req_plain_word),
      .req_tweak     (req_tweak),
      .rsp_valid     (rsp_valid),
      .rsp_auth_code (rsp_auth_code),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------- cipher
   function automatic logic [63:0] round_const(input int i);
      case (i)
         1: return 64'h13198A2E03707344;
         2: return 64'hA4093822299F31D0;
         3: return 64'h082EFA98EC4E6C89;
         4: return 64'h452821E638D01377;
         default: return 64'h0;
      endcase
   endfunction

   function automatic logic [63:0] shuffle(input logic [63:0] v, input logic [63:0] perm,
                                           input logic [15:0] step, input bit backward);
      logic [63:0] r;
      logic [3:0]  c;
      int          src;
      for (int d = 0; d < 16; d++) begin
         src = int'(perm[d*4 +: 4]);
         c = v[src*4 +: 4];
         if (step[d])
            c = backward ? {c[2:0], c[0] ^ c[3]} : {c[0] ^ c[1], c[3:1]};
         r[d*4 +: 4] = c;
      end
      return r;
   endfunction

   function automatic logic [63:0] sub_cells(input logic [63:0] v, input logic [63:0] box);
      logic [63:0] r;
      int          idx;
      for (int d = 0; d < 16; d++) begin
         idx = int'(v[d*4 +: 4]);
         r[d*4 +: 4] = box[idx*4 +: 4];
      end
      return r;
   endfunction

   function automatic logic [3:0] rotl(input logic [3:0] c, input int n);
      logic [7:0] w;
      w = {c, c} >> (4 - n);
      return w[3:0];
   endfunction

   function automatic logic [63:0] mix_cols(input logic [63:0] v);
      logic [63:0] r;
      logic [3:0]  a0, a4, a8, ac;
      for (int col = 0; col < 4; col++) begin
         a0 = v[col*4 +: 4];
         a4 = v[col*4 + 16 +: 4];
         a8 = v[col*4 + 32 +: 4];
         ac = v[col*4 + 48 +: 4];
         r[col*4 + 48 +: 4] = rotl(a8, 1) ^ rotl(a4, 2) ^ rotl(a0, 1);
         r[col*4 + 32 +: 4] = rotl(ac, 1) ^ rotl(a4, 1) ^ rotl(a0, 2);
         r[col*4 + 16 +: 4] = rotl(ac, 2) ^ rotl(a8, 1) ^ rotl(a0, 1);
         r[col*4 +: 4]      = rotl(ac, 1) ^ rotl(a8, 2) ^ rotl(a4, 1);
      end
      return r;
   endfunction

   function automatic logic [63:0] qarma_auth_code(input logic [63:0] data, input logic [63:0] twk,
                                                   input logic [63:0] w0, input logic [63:0] k0);
      logic [63:0] w1, t, s;
      w1 = {w0[0], w0[63:1]} ^ {63'd0, w0[63]};
      t = twk;
      s = data ^ w0;
      for (int i = 0; i < 5; i++) begin
         s = s ^ k0 ^ t ^ round_const(i);
         if (i > 0)
            s = mix_cols(shuffle(s, STATE_FWD_PERM, 16'h0, 1'b0));
         s = sub_cells(s, SBOX_F);
         t = shuffle(t, TWK_FWD_PERM, TWK_FWD_STEP, 1'b0);
      end
      // reflection
      s = s ^ w1 ^ t;
      s = mix_cols(shuffle(s, STATE_FWD_PERM, 16'h0, 1'b0));
      s = sub_cells(s, SBOX_F);
      s = mix_cols(shuffle(s, STATE_FWD_PERM, 16'h0, 1'b0));
      s = s ^ k0;
      s = sub_cells(shuffle(s, STATE_INV_PERM, 16'h0, 1'b0), SBOX_I);
      s = shuffle(mix_cols(s), STATE_INV_PERM, 16'h0, 1'b0);
      s = s ^ w0 ^ t;
      for (int i = 0; i < 5; i++) begin
         s = sub_cells(s, SBOX_I);
         if (i < 4)
            s = shuffle(mix_cols(s), STATE_INV_PERM, 16'h0, 1'b0);
         t = shuffle(t, TWK_INV_PERM, TWK_INV_STEP, 1'b1);
         s = s ^ round_const(4 - i) ^ k0 ^ t ^ ALPHA;
      end
      return s ^ w1;
   endfunction

   // ---------------------------------------------------------------- driver
   always @(posedge clock) begin : drive
      stim_op_type op;
      logic        nx_start;
      logic        nx_wr;
      if (reset) begin
         start     <= 1'b0;
         csr_wr_en <= 1'b0;
         n_sent    <= 0;
         stim_done <= 1'b0;
         key_w0 = '0;
         key_k0 = '0;
         draining = 1'b0;
         settle = 0;
      end else begin
         if (start && !busy) begin
            code_q.push_back(qarma_auth_code(req_plain_word, req_tweak, key_w0, key_k0));
            n_sent <= n_sent + 1;
         end
         if (csr_wr_en) begin
            if (csr_index == pac_pkg::CSR_KEY_UPPER)
               key_w0 = csr_wdata;
            else if (csr_index == pac_pkg::CSR_KEY_LOWER)
               key_k0 = csr_wdata;
         end
         nx_start = start && busy;
         nx_wr = 1'b0;
         if (!nx_start) begin
            if (settle > 0) begin
               settle--;
            end else if (draining) begin
               if (n_got == n_sent) begin
                  draining = 1'b0;
                  settle = SETTLE_TICKS;
               end
            end else if (stim_q.size() > 0) begin
               op = stim_q[0];
               case (op.kind)
                  OP_REQUEST: begin
                     if ($urandom_range(99) >= gap_pct) begin
                        void'(stim_q.pop_front());
                        nx_start = 1'b1;
                        req_plain_word <= op.a;
                        req_tweak      <= op.b;
                     end
                  end
                  OP_KEY_WRITE: begin
                     void'(stim_q.pop_front());
                     nx_wr = 1'b1;
                     csr_index <= op.a[pac_pkg::CSR_IDX_W-1:0];
                     csr_wdata <= op.b;
                  end
                  OP_DRAIN: begin
                     void'(stim_q.pop_front());
                     draining = 1'b1;
                  end
                  default: begin
                     void'(stim_q.pop_front());
                     gap_pct = int'(op.a[31:0]);
                  end
               endcase
            end
         end
         start     <= nx_start;
         csr_wr_en <= nx_wr;
         stim_done <= (stim_q.size() == 0) && !nx_start && !nx_wr && !draining && settle == 0;
      end
   end

   // --------------------------------------------------------------- monitor
   always @(posedge clock) begin : watch
      logic [63:0] want;
      if (reset) begin
         n_got <= 0;
      end else if (rsp_valid) begin
         if (n_got == n_sent) begin
            fails++;
            $error("auth_code: unexpected result, expected none, actual %h", rsp_auth_code);
         end else begin
            want = code_q.pop_front();
            n_got <= n_got + 1;
            if (rsp_auth_code !== want) begin
               fails++;
               $error("auth_code: expected %h, actual %h", want, rsp_auth_code);
            end
         end
      end
   end

   // -------------------------------------------------------------- stimulus
   function automatic logic [63:0] rand_word();
      logic [63:0] w;
      case ($urandom_range(3))
         0: w = 64'd1 << $urandom_range(63);
         1: w = ~(64'd1 << $urandom_range(63));
         default: w = {$urandom, $urandom};
      endcase
      return w;
   endfunction

   task automatic add_request(input logic [63:0] plain, input logic [63:0] twk);
      stim_q.push_back('{kind: OP_REQUEST, a: plain, b: twk});
   endtask

   task automatic add_gap(input int pct);
      stim_q.push_back('{kind: OP_GAP, a: 64'(pct), b: 64'd0});
   endtask

   task automatic add_keys(input logic [63:0] w0, input logic [63:0] k0);
      stim_q.push_back('{kind: OP_DRAIN, a: 64'd0, b: 64'd0});
      stim_q.push_back('{kind: OP_KEY_WRITE, a: 64'(pac_pkg::CSR_KEY_UPPER), b: w0});
      stim_q.push_back('{kind: OP_KEY_WRITE, a: 64'(pac_pkg::CSR_KEY_LOWER), b: k0});
   endtask

   initial begin : stimulus
      int gaps [3];
      gaps = '{8, 56, 0};

      add_gap(8);
      // reset keys
      add_request(64'd0, 64'd0);
      add_request(ONES, ONES);
      add_request(64'd0, ONES);
      add_request(ONES, 64'd0);
      add_keys(ONES, ONES);
      add_request(64'd0, 64'd0);
      add_request(ONES, ONES);
      add_request(64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA);
      add_request(64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555);
      add_keys(64'd0, ONES);
      add_request(64'd0, 64'd0);
      add_request(ONES, 64'd0);
      add_keys(ONES, 64'd0);
      add_request(64'd0, 64'd0);
      add_request(64'd0, ONES);
      add_keys(64'h8000000000000001, 64'h0123456789ABCDEF);
      add_request(64'd1, ~64'd1);
      add_request(64'd1 << 31, ~(64'd1 << 31));
      add_request(64'd1 << 32, ~(64'd1 << 32));
      add_request(64'd1 << 63, ~(64'd1 << 63));
      add_request({$urandom, $urandom}, {$urandom, $urandom});
      add_request({$urandom, $urandom}, {$urandom, $urandom});

      for (int p = 0; p < 3; p++) begin
         add_gap(gaps[p]);
         case (p)
            0: add_keys({$urandom, $urandom}, {$urandom, $urandom});
            1: add_keys(64'd0, {$urandom, $urandom});
            default: add_keys({$urandom, $urandom}, ONES);
         endcase
         for (int n = 0; n < 134; n++) begin
            if (n == 67)
               add_keys(rand_word(), rand_word());
            add_request(rand_word(), rand_word());
         end
      end

      wait (stim_done);
      while (n_got != n_sent)
         @(posedge clock);
      repeat (TAIL_TICKS) @(posedge clock);
      if (fails == 0 && code_q.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin : release_reset
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("status: fail");
      $finish;
   end

endmodule
